FILE: design/pse_pkg.sv
// Package for the p-code stack executor: opcodes, error codes, sizes and tables.
package pse_pkg;

    localparam int unsigned StackDepthDef   = 16;
    localparam int unsigned VarCountDef     = 16;
    localparam int unsigned ProgramWordsDef = 1024;

    localparam int unsigned ModeW = 5;
    localparam int unsigned DataW = 32;
    localparam int unsigned VidxW = 4;
    localparam int unsigned PcW   = 10;
    localparam int unsigned ErrW  = 3;

    typedef enum logic [ModeW-1:0] {
        OP_LDA   = 5'd0,
        OP_LDV   = 5'd1,
        OP_LDC   = 5'd2,
        OP_AFF   = 5'd3,
        OP_JMP   = 5'd4,
        OP_JIF   = 5'd5,
        OP_OR    = 5'd6,
        OP_AND   = 5'd7,
        OP_NOT   = 5'd8,
        OP_EG    = 5'd9,
        OP_SUP   = 5'd10,
        OP_SUPE  = 5'd11,
        OP_INF   = 5'd12,
        OP_DIFF  = 5'd13,
        OP_INFE  = 5'd14,
        OP_ADD   = 5'd15,
        OP_WRITE = 5'd16,
        OP_MULT  = 5'd17,
        OP_SUBST = 5'd18,
        OP_DIV   = 5'd19,
        OP_RD    = 5'd20,
        OP_STOP  = 5'd21
    } t_op;

    typedef enum logic [ErrW-1:0] {
        ERR_NONE      = 3'd0,
        ERR_OVERFLOW  = 3'd1,
        ERR_UNDERFLOW = 3'd2,
        ERR_DIV_ZERO  = 3'd3,
        ERR_BAD_ADDR  = 3'd4
    } t_err;

    function automatic logic [1:0] f_need(input logic [ModeW-1:0] mode);
        logic [1:0] n;
        n = 2'd0;
        case (mode)
            OP_JIF, OP_NOT, OP_WRITE, OP_RD: n = 2'd1;
            OP_AFF, OP_OR, OP_AND, OP_EG, OP_SUP, OP_SUPE, OP_INF, OP_DIFF,
            OP_INFE, OP_ADD, OP_MULT, OP_SUBST, OP_DIV: n = 2'd2;
            default: n = 2'd0;
        endcase
        return n;
    endfunction

endpackage

FILE: design/pcode_stack_executor.sv
// Top level of the p-code stack executor: sequencer, stack, variables, shared ALU.
//
//  channel  | ports                                              | dir
//  ---------+----------------------------------------------------+-----
//  command  | start, i_mode, i_constant_value, i_variable_index,
//           | i_jump_target, i_read_value                        | in
//  result   | o_strobe, o_next_pc, o_write_valid, o_write_value,
//           | o_halted, o_error_code, busy                       | out
//
// Most instructions go from start to the result strobe through a stack/variable
// read state, an execute state and the result state.
// Divide runs a radix-2 restoring divider for 32 steps plus a sign fix
// step; multiply takes one extra state for the registered product.
// busy is high from acceptance until the strobe cycle ends.
// Reset clears the stack pointer, pc, halt, error and the variable valid bits.
// The receiver cannot stall; each result is shown for one cycle.
module pcode_stack_executor #(
    parameter int unsigned STACK_DEPTH   = pse_pkg::StackDepthDef,
    parameter int unsigned VAR_COUNT     = pse_pkg::VarCountDef,
    parameter int unsigned PROGRAM_WORDS = pse_pkg::ProgramWordsDef
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [pse_pkg::ModeW-1:0]   i_mode,
    input  logic signed [pse_pkg::DataW-1:0] i_constant_value,
    input  logic [pse_pkg::VidxW-1:0]   i_variable_index,
    input  logic [pse_pkg::PcW-1:0]     i_jump_target,
    input  logic signed [pse_pkg::DataW-1:0] i_read_value,
    output logic                        o_strobe,
    output logic [pse_pkg::PcW-1:0]     o_next_pc,
    output logic                        o_write_valid,
    output logic signed [pse_pkg::DataW-1:0] o_write_value,
    output logic                        o_halted,
    output logic [pse_pkg::ErrW-1:0]    o_error_code
);
    import pse_pkg::*;

    localparam int unsigned SpW  = $clog2(STACK_DEPTH);
    localparam int unsigned LvlW = $clog2(STACK_DEPTH + 1);
    localparam int unsigned VaW  = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;
    localparam int unsigned PgW  = (PROGRAM_WORDS > 1) ? $clog2(PROGRAM_WORDS) : 1;
    localparam int unsigned DivCntW = $clog2(DataW + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_EXEC, S_MUL, S_DIV, S_DIVFIX, S_DONE
    } t_state;

    t_state r_state;

    logic [DataW-1:0] r_stack [STACK_DEPTH];
    logic [DataW-1:0] r_vars  [VAR_COUNT];
    logic [VAR_COUNT-1:0] r_vvalid;

    logic [LvlW-1:0]  r_level;
    logic [PgW-1:0]   r_pc;
    logic             r_halt;
    logic [ErrW-1:0]  r_err;

    logic [ModeW-1:0] r_mode;
    logic [DataW-1:0] r_cval, r_rval;
    logic [VidxW-1:0] r_vidx;
    logic [PcW-1:0]   r_jt;
    logic [DataW-1:0] r_a, r_b, r_var;
    logic             r_var_ok;

    logic [DataW-1:0] r_prod;
    logic [DataW-1:0] r_quo, r_rem, r_dvs;
    logic             r_qneg;
    logic [DivCntW-1:0] r_cnt;

    logic [PcW-1:0]   r_o_pc;
    logic             r_o_wv;
    logic [DataW-1:0] r_o_wval;
    logic             r_o_str;

    assign busy          = (r_state != S_IDLE);
    assign o_strobe      = r_o_str;
    assign o_next_pc     = r_o_pc;
    assign o_write_valid = r_o_wv;
    assign o_write_value = r_o_wval;
    assign o_halted      = r_halt;
    assign o_error_code  = r_err;

    // Read addresses
    logic [SpW-1:0] w_ia, w_ib;
    logic [LvlW-1:0] w_la, w_lb;
    assign w_la = r_level - LvlW'(1);
    assign w_lb = r_level - LvlW'(2);
    assign w_ia = w_la[SpW-1:0];
    assign w_ib = w_lb[SpW-1:0];

    logic [VaW-1:0] w_vi;
    logic           w_vi_ok;
    always_comb begin
        w_vi    = VaW'(r_vidx);
        w_vi_ok = ({{(32-VidxW){1'b0}}, r_vidx} < VAR_COUNT);
    end

    // Execute decode
    logic [1:0]       w_need;
    logic             w_is_push;
    logic             w_a_addr_ok, w_b_addr_ok, w_jt_ok;
    logic [DataW-1:0] w_alu;
    logic             w_binop;
    logic             w_lt, w_eq;
    logic [31:0]      w_pcn1, w_pcn2;
    logic [PgW-1:0]   w_pc1, w_pc2, w_jt_pg;

    always_comb begin
        w_need      = f_need(r_mode);
        w_is_push   = (r_mode <= ModeW'(OP_LDC));
        w_a_addr_ok = (r_a < DataW'(VAR_COUNT));
        w_b_addr_ok = (r_b < DataW'(VAR_COUNT));
        w_jt_ok     = ({{(32-PcW){1'b0}}, r_jt} < PROGRAM_WORDS);
        w_jt_pg     = PgW'(r_jt);
        w_pcn1      = 32'(r_pc) + 32'd1;
        w_pcn2      = 32'(r_pc) + 32'd2;
        w_pc1       = PgW'((w_pcn1 >= PROGRAM_WORDS) ? (w_pcn1 - PROGRAM_WORDS) : w_pcn1);
        w_pc2       = PgW'((w_pcn2 >= PROGRAM_WORDS) ? (w_pcn2 - PROGRAM_WORDS) : w_pcn2);
        w_lt        = ($signed(r_b) < $signed(r_a));
        w_eq        = (r_a == r_b);
        w_binop     = 1'b1;
        w_alu       = '0;
        case (r_mode)
            OP_OR:    w_alu = DataW'((r_a != '0) || (r_b != '0));
            OP_AND:   w_alu = DataW'((r_a != '0) && (r_b != '0));
            OP_EG:    w_alu = DataW'(w_eq);
            OP_SUP:   w_alu = DataW'(!w_lt && !w_eq);
            OP_SUPE:  w_alu = DataW'(!w_lt);
            OP_INF:   w_alu = DataW'(w_lt);
            OP_DIFF:  w_alu = DataW'(!w_eq);
            OP_INFE:  w_alu = DataW'(w_lt || w_eq);
            OP_ADD:   w_alu = r_b + r_a;
            OP_SUBST: w_alu = r_b - r_a;
            default:  w_binop = 1'b0;
        endcase
    end

    // Divider step
    logic [DataW:0]   w_rs;
    logic [DataW:0]   w_diff;
    always_comb begin
        w_rs   = {r_rem, r_quo[DataW-1]};
        w_diff = w_rs - {1'b0, r_dvs};
    end

    logic [DataW-1:0] w_abs_a, w_abs_b;
    assign w_abs_a = r_a[DataW-1] ? (DataW'(0) - r_a) : r_a;
    assign w_abs_b = r_b[DataW-1] ? (DataW'(0) - r_b) : r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_level  <= '0;
            r_pc     <= '0;
            r_halt   <= 1'b0;
            r_err    <= ERR_NONE;
            r_vvalid <= '0;
            r_o_str  <= 1'b0;
            r_o_wv   <= 1'b0;
            r_o_pc   <= '0;
            r_o_wval <= '0;
        end else begin
            r_o_str <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_mode  <= i_mode;
                        r_cval  <= i_constant_value;
                        r_vidx  <= i_variable_index;
                        r_jt    <= i_jump_target;
                        r_rval  <= i_read_value;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_a      <= r_stack[w_ia];
                    r_b      <= r_stack[w_ib];
                    r_var    <= r_vars[w_vi];
                    r_var_ok <= r_vvalid[w_vi];
                    r_state  <= S_EXEC;
                end
                S_EXEC: begin
                    r_o_wv   <= 1'b0;
                    r_o_wval <= '0;
                    r_state  <= S_DONE;
                    if (r_halt) begin
                        r_o_pc <= PcW'(r_pc);
                    end else if (r_mode < ModeW'(22) &&
                                 r_level < LvlW'(w_need)) begin
                        r_halt <= 1'b1;
                        r_err  <= ERR_UNDERFLOW;
                        r_o_pc <= PcW'(r_pc);
                    end else if (w_is_push && r_level >= LvlW'(STACK_DEPTH)) begin
                        r_halt <= 1'b1;
                        r_err  <= ERR_OVERFLOW;
                        r_o_pc <= PcW'(r_pc);
                    end else begin
                        r_o_pc <= PcW'(r_pc);
                        case (r_mode)
                            OP_LDA, OP_LDV: begin
                                if (!w_vi_ok) begin
                                    r_halt <= 1'b1;
                                    r_err  <= ERR_BAD_ADDR;
                                end else begin
                                    r_stack[r_level[SpW-1:0]] <= (r_mode == OP_LDA) ?
                                        DataW'(r_vidx) : (r_var_ok ? r_var : '0);
                                    r_level <= r_level + LvlW'(1);
                                    r_pc    <= w_pc2;
                                    r_o_pc  <= PcW'(w_pc2);
                                end
                            end
                            OP_LDC: begin
                                r_stack[r_level[SpW-1:0]] <= r_cval;
                                r_level <= r_level + LvlW'(1);
                                r_pc    <= w_pc2;
                                r_o_pc  <= PcW'(w_pc2);
                            end
                            OP_AFF: begin
                                if (!w_b_addr_ok) begin
                                    r_halt <= 1'b1;
                                    r_err  <= ERR_BAD_ADDR;
                                end else begin
                                    r_vars[VaW'(r_b)]   <= r_a;
                                    r_vvalid[VaW'(r_b)] <= 1'b1;
                                    r_level <= r_level - LvlW'(2);
                                    r_pc    <= w_pc1;
                                    r_o_pc  <= PcW'(w_pc1);
                                end
                            end
                            OP_JMP: begin
                                if (!w_jt_ok) begin
                                    r_halt <= 1'b1;
                                    r_err  <= ERR_BAD_ADDR;
                                end else begin
                                    r_pc   <= w_jt_pg;
                                    r_o_pc <= PcW'(w_jt_pg);
                                end
                            end
                            OP_JIF: begin
                                if (r_a == '0 && !w_jt_ok) begin
                                    r_halt <= 1'b1;
                                    r_err  <= ERR_BAD_ADDR;
                                end else begin
                                    r_level <= r_level - LvlW'(1);
                                    r_pc    <= (r_a != '0) ? w_pc2 : w_jt_pg;
                                    r_o_pc  <= PcW'((r_a != '0) ? w_pc2 : w_jt_pg);
                                end
                            end
                            OP_NOT: begin
                                r_stack[w_ia] <= DataW'(r_a == '0);
                                r_pc   <= w_pc1;
                                r_o_pc <= PcW'(w_pc1);
                            end
                            OP_WRITE: begin
                                r_o_wv   <= 1'b1;
                                r_o_wval <= r_a;
                                r_pc     <= w_pc1;
                                r_o_pc   <= PcW'(w_pc1);
                            end
                            OP_MULT: begin
                                r_prod  <= r_a * r_b;
                                r_state <= S_MUL;
                            end
                            OP_DIV: begin
                                if (r_a == '0) begin
                                    r_halt <= 1'b1;
                                    r_err  <= ERR_DIV_ZERO;
                                end else begin
                                    r_quo   <= w_abs_b;
                                    r_rem   <= '0;
                                    r_dvs   <= w_abs_a;
                                    r_qneg  <= r_a[DataW-1] ^ r_b[DataW-1];
                                    r_cnt   <= DivCntW'(DataW);
                                    r_state <= S_DIV;
                                end
                            end
                            OP_RD: begin
                                if (!w_a_addr_ok) begin
                                    r_halt <= 1'b1;
                                    r_err  <= ERR_BAD_ADDR;
                                end else begin
                                    r_vars[VaW'(r_a)]   <= r_rval;
                                    r_vvalid[VaW'(r_a)] <= 1'b1;
                                    r_level <= r_level - LvlW'(1);
                                    r_pc    <= w_pc1;
                                    r_o_pc  <= PcW'(w_pc1);
                                end
                            end
                            OP_STOP: begin
                                r_halt <= 1'b1;
                            end
                            default: begin
                                if (w_binop) begin
                                    r_stack[w_ib] <= w_alu;
                                    r_level <= r_level - LvlW'(1);
                                end
                                r_pc   <= w_pc1;
                                r_o_pc <= PcW'(w_pc1);
                            end
                        endcase
                    end
                    if (r_state == S_EXEC && !(r_mode == OP_MULT || r_mode == OP_DIV)) begin
                        r_o_str <= 1'b1;
                    end else if (r_halt || r_level < LvlW'(w_need) ||
                                 (r_mode == OP_DIV && r_a == '0)) begin
                        r_o_str <= 1'b1;
                    end
                end
                S_MUL: begin
                    r_stack[w_ib] <= r_prod;
                    r_level <= r_level - LvlW'(1);
                    r_pc    <= w_pc1;
                    r_o_pc  <= PcW'(w_pc1);
                    r_o_str <= 1'b1;
                    r_state <= S_DONE;
                end
                S_DIV: begin
                    if (!w_diff[DataW]) begin
                        r_rem <= w_diff[DataW-1:0];
                        r_quo <= {r_quo[DataW-2:0], 1'b1};
                    end else begin
                        r_rem <= w_rs[DataW-1:0];
                        r_quo <= {r_quo[DataW-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt - DivCntW'(1);
                    if (r_cnt == DivCntW'(1)) begin
                        r_state <= S_DIVFIX;
                    end
                end
                S_DIVFIX: begin
                    r_stack[w_ib] <= r_qneg ? (DataW'(0) - r_quo) : r_quo;
                    r_level <= r_level - LvlW'(1);
                    r_pc    <= w_pc1;
                    r_o_pc  <= PcW'(w_pc1);
                    r_o_str <= 1'b1;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= LvlW'(STACK_DEPTH))
        else $error("stack level beyond depth");

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt)
        else $error("halt flag cleared");

    a_err_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != ERR_NONE) |-> r_halt)
        else $error("error without halt");

    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_str |-> (r_state == S_DONE))
        else $error("strobe outside done");

    a_wv_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_str && r_o_wv) |-> !$past(r_halt))
        else $error("write while halted");

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for pcode_stack_executor: queued command driver, result monitor.
module tb_top;
    import pse_pkg::*;

    typedef struct packed {
        logic [ModeW-1:0] mode;
        logic [DataW-1:0] cval;
        logic [VidxW-1:0] vidx;
        logic [PcW-1:0]   jt;
        logic [DataW-1:0] rv;
        logic             drain;
        logic [6:0]       idle;
    } cmd_t;

    typedef struct packed {
        logic [PcW-1:0]   pc;
        logic             wvalid;
        logic [DataW-1:0] wval;
        logic             halted;
        logic [ErrW-1:0]  err;
    } step_t;

    localparam int Depth = 16;
    localparam int NumItems = 1250;
    localparam int CycleLimit = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [ModeW-1:0] i_mode = '0;
    logic signed [DataW-1:0] i_constant_value = '0;
    logic [VidxW-1:0] i_variable_index = '0;
    logic [PcW-1:0] i_jump_target = '0;
    logic signed [DataW-1:0] i_read_value = '0;
    logic o_strobe;
    logic [PcW-1:0] o_next_pc;
    logic o_write_valid;
    logic signed [DataW-1:0] o_write_value;
    logic o_halted;
    logic [ErrW-1:0] o_error_code;

    pcode_stack_executor dut (
        .i_clk, .i_rst_n, .start, .busy, .i_mode, .i_constant_value,
        .i_variable_index, .i_jump_target, .i_read_value, .o_strobe, .o_next_pc,
        .o_write_valid, .o_write_value, .o_halted, .o_error_code
    );

    always #5 i_clk = ~i_clk;

    // machine copies: 0 follows the DUT, 1 follows the generator, 2 is scratch
    logic [DataW-1:0] stk [3][Depth];
    logic [DataW-1:0] vars [3][16];
    int               lvl [3];
    logic [PcW-1:0]   pcr [3];
    logic             hlt [3];
    logic [ErrW-1:0]  errr [3];

    cmd_t  pend_q [$];
    step_t expect_q [$];
    cmd_t  cur;
    int    n_gen = 0, n_acc = 0, n_checked = 0, n_writes = 0, n_fail = 0, cycles = 0;
    bit    nstart;
    step_t got;

    function automatic logic [31:0] sdiv(logic [31:0] b, logic [31:0] a);
        logic [31:0] mb, ma, q;
        mb = b[31] ? -b : b;
        ma = a[31] ? -a : a;
        q = mb / ma;
        return (a[31] ^ b[31]) ? -q : q;
    endfunction

    function automatic void exec_step(int c, cmd_t x, output step_t r);
        logic [31:0] a, b, v;
        logic [ErrW-1:0] e;
        logic bin;
        logic [PcW-1:0] np;
        int need;
        r = '0;
        if (!hlt[c]) begin
            np = pcr[c];
            e = ERR_NONE;
            bin = 1'b0;
            v = '0;
            case (x.mode)
                OP_JIF, OP_NOT, OP_WRITE, OP_RD: need = 1;
                OP_AFF, OP_OR, OP_AND, OP_EG, OP_SUP, OP_SUPE, OP_INF, OP_DIFF,
                OP_INFE, OP_ADD, OP_MULT, OP_SUBST, OP_DIV: need = 2;
                default: need = 0;
            endcase
            if (lvl[c] < need) e = ERR_UNDERFLOW;
            else if (x.mode <= OP_LDC && lvl[c] >= Depth) e = ERR_OVERFLOW;
            a = (lvl[c] >= 1) ? stk[c][lvl[c]-1] : '0;
            b = (lvl[c] >= 2) ? stk[c][lvl[c]-2] : '0;
            if (e == ERR_NONE) begin
                case (x.mode)
                    OP_LDA, OP_LDV, OP_LDC: begin
                        stk[c][lvl[c]] = (x.mode == OP_LDA) ? 32'(x.vidx) :
                                         (x.mode == OP_LDV) ? vars[c][x.vidx] : x.cval;
                        lvl[c]++;
                        np = PcW'(pcr[c] + PcW'(2));
                    end
                    OP_AFF: begin
                        if (b >= 16) e = ERR_BAD_ADDR;
                        else begin
                            vars[c][b[3:0]] = a;
                            lvl[c] -= 2;
                            np = PcW'(pcr[c] + PcW'(1));
                        end
                    end
                    OP_JMP: np = x.jt;
                    OP_JIF: begin
                        np = (a != 0) ? PcW'(pcr[c] + PcW'(2)) : x.jt;
                        lvl[c]--;
                    end
                    OP_OR:    begin v = 32'(a != 0 || b != 0); bin = 1'b1; end
                    OP_AND:   begin v = 32'(a != 0 && b != 0); bin = 1'b1; end
                    OP_NOT: begin
                        stk[c][lvl[c]-1] = 32'(a == 0);
                        np = PcW'(pcr[c] + PcW'(1));
                    end
                    OP_EG:    begin v = 32'(a == b); bin = 1'b1; end
                    OP_SUP:   begin v = 32'($signed(b) > $signed(a)); bin = 1'b1; end
                    OP_SUPE:  begin v = 32'($signed(b) >= $signed(a)); bin = 1'b1; end
                    OP_INF:   begin v = 32'($signed(b) < $signed(a)); bin = 1'b1; end
                    OP_DIFF:  begin v = 32'(a != b); bin = 1'b1; end
                    OP_INFE:  begin v = 32'($signed(b) <= $signed(a)); bin = 1'b1; end
                    OP_ADD:   begin v = a + b; bin = 1'b1; end
                    OP_WRITE: begin
                        r.wvalid = 1'b1;
                        r.wval = a;
                        np = PcW'(pcr[c] + PcW'(1));
                    end
                    OP_MULT:  begin v = a * b; bin = 1'b1; end
                    OP_SUBST: begin v = b - a; bin = 1'b1; end
                    OP_DIV: begin
                        if (a == 0) e = ERR_DIV_ZERO;
                        else begin v = sdiv(b, a); bin = 1'b1; end
                    end
                    OP_RD: begin
                        if (a >= 16) e = ERR_BAD_ADDR;
                        else begin
                            vars[c][a[3:0]] = x.rv;
                            lvl[c]--;
                            np = PcW'(pcr[c] + PcW'(1));
                        end
                    end
                    OP_STOP: hlt[c] = 1'b1;
                    default: np = PcW'(pcr[c] + PcW'(1));
                endcase
                if (bin) begin
                    lvl[c]--;
                    stk[c][lvl[c]-1] = v;
                    np = PcW'(pcr[c] + PcW'(1));
                end
            end
            if (e != ERR_NONE) begin
                hlt[c] = 1'b1;
                errr[c] = e;
                np = pcr[c];
                r.wvalid = 1'b0;
                r.wval = '0;
            end
            pcr[c] = np;
        end
        r.pc = pcr[c];
        r.halted = hlt[c];
        r.err = errr[c];
    endfunction

    function automatic bit stays_running(cmd_t x);
        step_t r;
        lvl[2] = lvl[1];
        pcr[2] = pcr[1];
        hlt[2] = hlt[1];
        errr[2] = errr[1];
        for (int i = 0; i < Depth; i++) stk[2][i] = stk[1][i];
        for (int i = 0; i < 16; i++) vars[2][i] = vars[1][i];
        exec_step(2, x, r);
        return !r.halted;
    endfunction

    function automatic cmd_t rand_cmd(logic [ModeW-1:0] m);
        cmd_t x;
        logic [DataW-1:0] ext [5];
        ext = '{32'h0, 32'h1, 32'hffffffff, 32'h80000000, 32'h7fffffff};
        x.mode = m;
        x.cval = ($urandom_range(3) == 0) ? ext[$urandom_range(4)] : $urandom;
        x.vidx = VidxW'($urandom);
        x.jt = PcW'($urandom);
        x.rv = $urandom;
        x.drain = 1'b0;
        x.idle = '0;
        return x;
    endfunction

    task automatic queue_cmd(cmd_t x);
        step_t r;
        int pct [4];
        pct = '{0, 48, 0, 10};
        exec_step(1, x, r);
        x.idle = 7'(pct[(n_gen / 150) % 4]);
        x.drain = (n_gen == 600);
        pend_q.push_back(x);
        n_gen++;
    endtask

    task automatic op(logic [ModeW-1:0] m, logic [31:0] cv, logic [3:0] vi,
                      logic [9:0] jt, logic [31:0] rv);
        cmd_t x;
        x = rand_cmd(m);
        x.cval = cv;
        x.vidx = vi;
        x.jt = jt;
        x.rv = rv;
        queue_cmd(x);
    endtask

    task automatic gen_checked(logic [ModeW-1:0] m);
        cmd_t x;
        x = rand_cmd(m);
        if (m == OP_LDA) x.vidx = VidxW'($urandom_range(15));
        if (stays_running(x)) queue_cmd(x);
    endtask

    // driver: hold start until accepted, then advance to the next queued beat
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            nstart = start;
            if (start && !busy) begin
                exec_step(0, cur, got);
                expect_q.push_back(got);
                n_acc++;
                nstart = 1'b0;
            end
            if (!nstart && pend_q.size() > 0 && !(pend_q[0].drain && expect_q.size() > 0)
                    && $urandom_range(99) >= pend_q[0].idle) begin
                cur = pend_q.pop_front();
                i_mode <= cur.mode;
                i_constant_value <= cur.cval;
                i_variable_index <= cur.vidx;
                i_jump_target <= cur.jt;
                i_read_value <= cur.rv;
                nstart = 1'b1;
            end
            start <= nstart;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            got = '{o_next_pc, o_write_valid, o_write_value, o_halted, o_error_code};
            if (expect_q.size() == 0) begin
                $display("%0t: unexpected result pc=%0d wv=%0b wval=%h halt=%0b err=%0d",
                         $time, o_next_pc, o_write_valid, o_write_value, o_halted,
                         o_error_code);
                n_fail++;
            end else begin
                if (expect_q[0] !== got) begin
                    $display("%0t: mismatch expected pc=%0d wv=%0b wval=%h halt=%0b err=%0d",
                             $time, expect_q[0].pc, expect_q[0].wvalid, expect_q[0].wval,
                             expect_q[0].halted, expect_q[0].err);
                    $display("%0t:          actual   pc=%0d wv=%0b wval=%h halt=%0b err=%0d",
                             $time, got.pc, got.wvalid, got.wval, got.halted, got.err);
                    n_fail++;
                end
                if (got.wvalid) n_writes++;
                void'(expect_q.pop_front());
                n_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == 11) i_rst_n <= 1'b1;
        if (cycles > CycleLimit) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int k, ending;
        for (int c = 0; c < 3; c++) begin
            lvl[c] = 0;
            pcr[c] = '0;
            hlt[c] = 1'b0;
            errr[c] = ERR_NONE;
            for (int i = 0; i < Depth; i++) stk[c][i] = '0;
            for (int i = 0; i < 16; i++) vars[c][i] = '0;
        end
        op(OP_LDC, 32'h7fffffff, 4'hf, 10'h3ff, 32'hffffffff);
        op(OP_LDC, 32'h80000000, 4'h0, 10'h0, 32'h0);
        op(OP_ADD, 0, 0, 0, 0);
        op(OP_LDC, 32'h80000000, 0, 0, 0);
        op(OP_LDC, 32'hffffffff, 0, 0, 0);
        op(OP_DIV, 0, 0, 0, 0);
        op(OP_SUP, 0, 0, 0, 0);
        op(OP_WRITE, 0, 0, 0, 0);
        op(OP_JIF, 0, 0, 10'h3ff, 0);
        op(OP_LDA, 0, 4'hf, 0, 0);
        op(OP_LDC, 5, 0, 0, 0);
        op(OP_AFF, 0, 0, 0, 0);
        op(OP_LDV, 0, 4'hf, 0, 0);
        op(OP_LDA, 0, 4'h3, 0, 0);
        op(OP_RD, 0, 0, 0, 32'h80000000);
        op(OP_LDC, 5, 0, 0, 0);
        op(OP_EG, 0, 0, 0, 0);
        op(OP_LDC, 0, 0, 0, 0);
        op(OP_OR, 0, 0, 0, 0);
        op(OP_LDC, 0, 0, 0, 0);
        op(OP_AND, 0, 0, 0, 0);
        op(OP_NOT, 0, 0, 0, 0);
        op(OP_JIF, 0, 0, 10'h000, 0);
        op(OP_JMP, 0, 0, 10'h3ff, 0);
        op(5'd31, 0, 0, 0, 0);
        while (n_gen < NumItems) begin
            k = $urandom_range(9);
            if (k == 0 && lvl[1] <= Depth - 2) begin
                op(OP_LDA, 0, 4'($urandom), 0, 0);
                gen_checked(($urandom_range(1) == 0) ? OP_LDC : OP_LDV);
                gen_checked(OP_AFF);
            end else if (k == 1 && lvl[1] < Depth) begin
                op(OP_LDA, 0, 4'($urandom), 0, 0);
                gen_checked(OP_RD);
            end else if (k < 5) begin
                gen_checked(5'($urandom_range(2)));
            end else begin
                gen_checked(5'($urandom_range(31)));
            end
        end
        // finish with one sticky halt, then a few beats that must be ignored
        ending = $urandom_range(4);
        while (ending != 0 && ending != 1 && lvl[1] > Depth - 2) op(OP_ADD, 0, 0, 0, 0);
        case (ending)
            0: op(OP_STOP, 0, 0, 0, 0);
            1: begin
                while (lvl[1] < Depth) op(OP_LDC, $urandom, 0, 0, 0);
                op(OP_LDV, 0, 4'($urandom), 0, 0);
            end
            2: begin
                while (lvl[1] >= 2) op(OP_MULT, 0, 0, 0, 0);
                op(OP_SUBST, 0, 0, 0, 0);
            end
            3: begin
                op(OP_LDC, 32'h0, 0, 0, 0);
                op(OP_DIV, 0, 0, 0, 0);
            end
            default: begin
                op(OP_LDC, 32'h80000010, 0, 0, 0);
                op(OP_RD, 0, 0, 0, $urandom);
            end
        endcase
        for (int i = 0; i < 6; i++) queue_cmd(rand_cmd(5'($urandom_range(31))));

        wait (i_rst_n);
        wait (pend_q.size() == 0 && !start && expect_q.size() == 0);
        repeat (60) @(posedge i_clk);
        $display("ran %0d instructions, checked %0d results, %0d console writes",
                 n_acc, n_checked, n_writes);
        $display("closing fault kind %0d, %0d mismatches", ending, n_fail);
        if (n_fail == 0 && expect_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
